/* hw/rtl/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int PRIO_W           = 15;
  localparam int REQ_PRIO_W       = 16;
  localparam int PORT_PAYLOAD_W   = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NONPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY_RM = 2'd3;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [PRIO_W-1:0] prio;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl,
  input  wire logic [PAYLOAD_BITS-1:0] new_payload,
  input  wire logic                    occupied,
  input  wire logic                    prev_keep,
  input  wire logic [PRIO_W-1:0]       prev_prio,
  input  wire logic [PAYLOAD_BITS-1:0] prev_payload,
  input  wire logic [PRIO_W-1:0]       succ_prio,
  input  wire logic [PAYLOAD_BITS-1:0] succ_payload,
  output logic                         keep,
  output logic [PRIO_W-1:0]            prio,
  output logic [PAYLOAD_BITS-1:0]      data,
  output logic [PRIO_W-1:0]            prio_next,
  output logic [PAYLOAD_BITS-1:0]      data_next
);

  // equal priorities stay ahead of the newcomer
  assign keep = occupied && (prio >= ctl.prio);

  always_comb begin
    prio_next = prio;
    data_next = data;
    if (ctl.ins && !keep) begin
      if (prev_keep) begin
        prio_next = ctl.prio;
        data_next = new_payload;
      end else begin
        prio_next = prev_prio;
        data_next = prev_payload;
      end
    end else if (ctl.rem) begin
      prio_next = succ_prio;
      data_next = succ_payload;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    data <= data_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/stable_priority_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue, highest priority first, arrival order among equals.
// Request channel (req_valid / req_stall): opcode 0 inserts priority_req with
// payload, opcode 1 removes the head. Nonpositive priorities and inserts into
// a full queue are refused with a status code, as is a remove on empty.
// Response channel (rsp_valid / rsp_stall): one beat per request, carrying the
// status and the head, occupancy and empty flag after that request.
// The store is a row of DEPTH cells; every cell decides combinationally whether
// it keeps its entry, takes the new item, or takes a neighbor's entry.
// Each response is registered before it reaches the response outputs.
// Throughput: one request per cycle while req_stall is low.
// A response register plus a skid register sit at the output; when the
// receiver stalls, one more request is taken into the skid register and then
// req_stall rises until the response register drains.
// Reset (rst, synchronous) empties the queue and drops any pending response;
// no clearing pass is needed since only occupied cells are ever read.
module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int CNT_W       = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire logic                      opcode,
  input  wire logic [REQ_PRIO_W-1:0]     priority_req,
  input  wire logic [PORT_PAYLOAD_W-1:0] payload,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic [1:0]                     status,
  output logic [PRIO_W-1:0]              head_priority,
  output logic [PORT_PAYLOAD_W-1:0]      head_payload,
  output logic [CNT_W-1:0]               occupancy,
  output logic                           is_empty
);

  typedef struct packed {
    logic [1:0]                status;
    logic [PRIO_W-1:0]         prio;
    logic [PORT_PAYLOAD_W-1:0] data;
    logic [CNT_W-1:0]          count;
    logic                      empty;
  } rsp_t;

  logic                    accept;
  logic                    take;
  logic                    nonpos;
  logic                    full;
  logic                    ins_ok;
  logic                    rem_ok;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        fill_next;
  logic [PAYLOAD_BITS-1:0] new_payload;
  logic [PORT_PAYLOAD_W-1:0] head_data_ext;
  cell_ctl_t               ctl;
  rsp_t                    result;
  rsp_t                    rsp_q;
  rsp_t                    skid_q;
  logic                    skid_valid;

  logic                    cell_keep [DEPTH];
  logic [PRIO_W-1:0]       cell_prio [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_data [DEPTH];
  logic [PRIO_W-1:0]       cell_prio_next [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_data_next [DEPTH];

  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign take      = rsp_valid && !rsp_stall;

  assign nonpos = priority_req[REQ_PRIO_W-1] || (priority_req == '0);
  assign full   = (fill == CNT_W'(DEPTH));
  assign ins_ok = accept && (opcode == OP_INSERT) && !nonpos && !full;
  assign rem_ok = accept && (opcode == OP_REMOVE) && (fill != '0);

  assign ctl.ins  = ins_ok;
  assign ctl.rem  = rem_ok;
  assign ctl.prio = priority_req[PRIO_W-1:0];

  generate
    if (PAYLOAD_BITS <= PORT_PAYLOAD_W) begin : g_narrow
      assign new_payload = payload[PAYLOAD_BITS-1:0];
      assign head_data_ext = PORT_PAYLOAD_W'(cell_data_next[0]);
    end else begin : g_wide
      assign new_payload = PAYLOAD_BITS'(payload);
      assign head_data_ext = cell_data_next[0][PORT_PAYLOAD_W-1:0];
    end
  endgenerate

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    prev_keep;
    logic [PRIO_W-1:0]       prev_prio;
    logic [PAYLOAD_BITS-1:0] prev_data;
    logic [PRIO_W-1:0]       succ_prio;
    logic [PAYLOAD_BITS-1:0] succ_data;

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_prio = ctl.prio;
      assign prev_data = new_payload;
    end else begin : g_mid
      assign prev_keep = cell_keep[i-1];
      assign prev_prio = cell_prio[i-1];
      assign prev_data = cell_data[i-1];
    end

    // last cell refills with its own (now unused) contents on remove
    if (i == DEPTH - 1) begin : g_last
      assign succ_prio = cell_prio[i];
      assign succ_data = cell_data[i];
    end else begin : g_inner
      assign succ_prio = cell_prio[i+1];
      assign succ_data = cell_data[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_payload (new_payload),
      .occupied    (fill > CNT_W'(i)),
      .prev_keep   (prev_keep),
      .prev_prio   (prev_prio),
      .prev_payload(prev_data),
      .succ_prio   (succ_prio),
      .succ_payload(succ_data),
      .keep        (cell_keep[i]),
      .prio        (cell_prio[i]),
      .data        (cell_data[i]),
      .prio_next   (cell_prio_next[i]),
      .data_next   (cell_data_next[i])
    );
  end

  always_comb begin
    fill_next = fill;
    if (ins_ok) begin
      fill_next = fill + CNT_W'(1);
    end else if (rem_ok) begin
      fill_next = fill - CNT_W'(1);
    end
  end

  always_comb begin
    result.status = ST_DONE;
    if (opcode == OP_INSERT) begin
      if (nonpos) begin
        result.status = ST_NONPOS;
      end else if (full) begin
        result.status = ST_FULL;
      end
    end else if (fill == '0) begin
      result.status = ST_EMPTY_RM;
    end
    result.count = fill_next;
    result.empty = (fill_next == '0);
    result.prio  = result.empty ? '0 : cell_prio_next[0];
    result.data  = result.empty ? '0 : head_data_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (take || !rsp_valid) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          rsp_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take || !rsp_valid) begin
      if (skid_valid) begin
        rsp_q <= skid_q;
      end else if (accept) begin
        rsp_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign status        = rsp_q.status;
  assign head_priority = rsp_q.prio;
  assign head_payload  = rsp_q.data;
  assign occupancy     = rsp_q.count;
  assign is_empty      = rsp_q.empty;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_skid_behind_rsp: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid register holds a beat while response register is empty");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> (fill == $past(fill) + CNT_W'(1)))
    else $error("accepted insert did not grow the queue");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

endmodule

`default_nettype wire

/* dv/stable_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH_DEF + 1);

  typedef struct {
    logic [1:0]                status;
    logic [PRIO_W-1:0]         prio;
    logic [PORT_PAYLOAD_W-1:0] pay;
    logic [CNT_W-1:0]          occ;
    logic                      empty;
  } head_view_t;

  // sorted store mirror plus the queue of head views still owed by the block
  class pq_scoreboard;
    logic [PRIO_W-1:0]         slot_prio[DEPTH_DEF];
    logic [PORT_PAYLOAD_W-1:0] slot_pay[DEPTH_DEF];
    int                        fill = 0;
    head_view_t                owed_heads[$];
    int                        mismatches = 0;

    function void flag(string what, logic [31:0] exp_val, logic [31:0] act_val);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0h, got %0h", $time, what, exp_val, act_val);
    endfunction

    function void note_request(logic op, logic [REQ_PRIO_W-1:0] req_prio,
                               logic [PORT_PAYLOAD_W-1:0] pay);
      head_view_t v;
      int         pos;
      int         i;
      v.status = ST_DONE;
      if (op == OP_INSERT) begin
        if (req_prio[REQ_PRIO_W-1] || req_prio == '0) begin
          v.status = ST_NONPOS;
        end else if (fill == DEPTH_DEF) begin
          v.status = ST_FULL;
        end else begin
          // new entry lands behind every entry of equal or higher priority
          pos = 0;
          while (pos < fill && slot_prio[pos] >= req_prio[PRIO_W-1:0]) pos++;
          for (i = fill; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_pay[i]  = slot_pay[i-1];
          end
          slot_prio[pos] = req_prio[PRIO_W-1:0];
          slot_pay[pos]  = pay;
          fill++;
        end
      end else if (fill == 0) begin
        v.status = ST_EMPTY_RM;
      end else begin
        for (i = 0; i + 1 < fill; i++) begin
          slot_prio[i] = slot_prio[i+1];
          slot_pay[i]  = slot_pay[i+1];
        end
        fill--;
      end
      v.prio  = (fill != 0) ? slot_prio[0] : '0;
      v.pay   = (fill != 0) ? slot_pay[0] : '0;
      v.occ   = CNT_W'(fill);
      v.empty = (fill == 0);
      owed_heads.push_back(v);
    endfunction

    function void check_response(head_view_t got);
      head_view_t want;
      if (owed_heads.size() == 0) begin
        flag("unexpected response beat, status", '0, 32'(got.status));
        return;
      end
      want = owed_heads.pop_front();
      if (got.status !== want.status)
        flag("status", 32'(want.status), 32'(got.status));
      if (got.prio !== want.prio)
        flag("head_priority", 32'(want.prio), 32'(got.prio));
      if (got.pay !== want.pay) flag("head_payload", want.pay, got.pay);
      if (got.occ !== want.occ)
        flag("occupancy", 32'(want.occ), 32'(got.occ));
      if (got.empty !== want.empty)
        flag("is_empty", 32'(want.empty), 32'(got.empty));
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  logic                      opcode = OP_INSERT;
  logic [REQ_PRIO_W-1:0]     priority_req = '0;
  logic [PORT_PAYLOAD_W-1:0] payload = '0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  logic [1:0]                status;
  logic [PRIO_W-1:0]         head_priority;
  logic [PORT_PAYLOAD_W-1:0] head_payload;
  logic [CNT_W-1:0]          occupancy;
  logic                      is_empty;

  int send_idle_pct  = 0;
  int rsp_stall_pct  = 0;
  int holdoff_cycles = 0;

  pq_scoreboard sb = new;

  stable_priority_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .opcode       (opcode),
    .priority_req (priority_req),
    .payload      (payload),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .head_priority(head_priority),
    .head_payload (head_payload),
    .occupancy    (occupancy),
    .is_empty     (is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("stable_priority_queue_unit verification failed");
    $finish;
  end

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_cycles > 0) begin
        rsp_stall <= 1'b1;
        holdoff_cycles--;
      end else begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    head_view_t got;
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(opcode, priority_req, payload);
      if (rsp_valid && !rsp_stall) begin
        got.status = status;
        got.prio   = head_priority;
        got.pay    = head_payload;
        got.occ    = occupancy;
        got.empty  = is_empty;
        sb.check_response(got);
      end
    end
  end

  task automatic send_req(input logic op, input logic [REQ_PRIO_W-1:0] prio,
                          input logic [PORT_PAYLOAD_W-1:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    opcode       <= op;
    priority_req <= prio;
    payload      <= pay;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic send_random(input int insert_pct);
    logic                  op;
    logic [REQ_PRIO_W-1:0] prio;
    int                    sel;
    op  = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    sel = $urandom_range(99);
    if (sel < 3)
      prio = '0;
    else if (sel < 10)
      prio = {1'b1, 15'($urandom)};
    else if (sel < 60)
      prio = REQ_PRIO_W'($urandom_range(1, 6));  // narrow range to force ties
    else if (sel < 70)
      prio = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h0001;
    else
      prio = REQ_PRIO_W'($urandom_range(1, 32767));
    send_req(op, prio, $urandom);
  endtask

  int idle_by_phase[4]  = '{0, 54, 0, 28};
  int stall_by_phase[4] = '{0, 0, 54, 28};

  initial begin
    int blk;
    int n;
    int insert_pct;
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_req(OP_REMOVE, 16'h0000, 32'h0);
    send_req(OP_INSERT, 16'h0000, 32'h1111_1111);
    send_req(OP_INSERT, 16'h8000, 32'h2222_2222);
    send_req(OP_INSERT, 16'hFFFF, 32'h3333_3333);
    send_req(OP_INSERT, 16'h7FFF, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 16'h0001, 32'h0000_0000);
    // equal priorities must come out in arrival order
    send_req(OP_INSERT, 16'h0005, 32'h0000_000A);
    send_req(OP_INSERT, 16'h0005, 32'h0000_000B);
    send_req(OP_INSERT, 16'h0005, 32'h0000_000C);
    send_req(OP_INSERT, 16'h7FFF, 32'h5A5A_5A5A);
    send_req(OP_INSERT, 16'h5555, 32'hA5A5_A5A5);
    send_req(OP_INSERT, 16'h2AAA, 32'h5555_AAAA);
    repeat (9) send_req(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);

    for (blk = 0; blk < 8; blk++) begin
      send_idle_pct = idle_by_phase[blk % 4];
      rsp_stall_pct = stall_by_phase[blk % 4];
      // receiver holds off while the sender keeps offering beats back to back
      if (blk % 4 == 0) holdoff_cycles = 50;
      insert_pct = 85;
      for (n = 0; n < 230; n++) begin
        if (n % 40 == 39) begin
          case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
          endcase
        end
        send_random(insert_pct);
      end
    end
    req_valid     <= 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;

    waited = 0;
    while (sb.owed_heads.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed_heads.size() == 0)
      $display("stable_priority_queue_unit verification clean");
    else
      $display("stable_priority_queue_unit verification failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue_unit.sv
dv/stable_priority_queue_unit_tb.sv
